/* rtl/ecft_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecft_pkg
// Shared types and constants for the elliptic curve Frobenius trace block.
// ----------------------------------------------------------------------------
package ecft_pkg;

  // discriminant weights of 4a^3 + 27b^2
  localparam int unsigned DiscK4  = 4;
  localparam int unsigned DiscK27 = 27;

  localparam int unsigned TraceW  = 8;
  localparam int unsigned CountW  = 11;
  localparam int unsigned OutW    = ((1 + TraceW + CountW + 7) / 8) * 8;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_RED_A,
    ST_RED_B,
    ST_A2,
    ST_A3,
    ST_A4,
    ST_B2,
    ST_B27,
    ST_DISC,
    ST_X2,
    ST_X3,
    ST_AX,
    ST_FSUM,
    ST_PSQ,
    ST_PMUL,
    ST_PCHK,
    ST_NEXT,
    ST_OUT
  } state_e;

endpackage

/* rtl/ecft_modmul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecft_modmul
// Bit-serial modular multiplier: x * y mod p, one bit of y per cycle, msb
// first, with a double-and-add step and two compare-subtracts per cycle.
// ----------------------------------------------------------------------------
module ecft_modmul #(
  parameter int unsigned PB = 10,
  parameter int unsigned YW = 10
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [PB-1:0] x_i,     // must be below p
  input  logic [YW-1:0] y_i,
  input  logic [PB-1:0] p_i,
  output logic          done_o,
  output logic [PB-1:0] prod_o
);

  localparam int unsigned CW = $clog2(YW + 1);

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [PB-1:0] acc_q, acc_d;
  logic [PB-1:0] x_q, x_d;
  logic [PB-1:0] p_q, p_d;
  logic [YW-1:0] y_q, y_d;

  logic [PB:0] dbl, dbl_r, sum, sum_r, p_ext;

  always_comb begin
    p_ext = {1'b0, p_q};
    dbl   = {acc_q, 1'b0};
    dbl_r = (dbl >= p_ext) ? dbl - p_ext : dbl;
    sum   = dbl_r + (y_q[YW-1] ? {1'b0, x_q} : '0);
    sum_r = (sum >= p_ext) ? sum - p_ext : sum;
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    p_d    = p_q;
    y_d    = y_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CW'(YW);
      acc_d  = '0;
      x_d    = x_i;
      p_d    = p_i;
      y_d    = y_i;
    end else if (busy_q) begin
      acc_d = sum_r[PB-1:0];
      y_d   = {y_q[YW-2:0], 1'b0};
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    p_q   <= p_d;
    y_q   <= y_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

/* rtl/elliptic_curve_frobenius_trace.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elliptic_curve_frobenius_trace
// Trace of Frobenius and point count of y^2 = x^3 + ax + b over GF(p).
// ----------------------------------------------------------------------------
// One beat in gives one beat out. Every product goes through a single
// bit-serial modular multiplier with a YW-bit y operand (YW = max(PRIME_BITS, 5)).
// The discriminant costs seven products; then for each x in 0..p-1 three
// products form f(x), and for a nonzero f(x) Euler's criterion takes
// PRIME_BITS squarings plus one multiply per set bit of (p-1)/2. A new beat
// is accepted while the previous result waits on the master side;
// prime_modulus is taken from the cfg channel when idle.
// ----------------------------------------------------------------------------
module elliptic_curve_frobenius_trace #(
  parameter int unsigned PRIME_BITS = 10
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [PRIME_BITS-1:0]       cfg_data_i,     // prime_modulus
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // coeff_a, coeff_b, zero fill
  input  logic [((2*PRIME_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // good_reduction, frobenius_trace, point_count, zero fill
  output logic [ecft_pkg::OutW-1:0]   m_axis_tdata
);

  localparam int unsigned PB  = PRIME_BITS;
  localparam int unsigned YW  = (PB > 5) ? PB : 5;
  localparam int unsigned BW  = $clog2(PB);
  localparam int unsigned SW  = PB + 2;
  localparam int unsigned WW  = PB + 4;
  localparam int unsigned TW  = ecft_pkg::TraceW;
  localparam int unsigned NW  = ecft_pkg::CountW;

  ecft_pkg::state_e state_q, state_d;

  logic [PB-1:0] p_q;
  logic [PB-1:0] a_q, b_q, t_q, x_q, f_q, acc_q;
  logic [BW-1:0] bi_q;
  logic signed [SW-1:0] sum_q;
  logic          good_q;
  logic          issued_q;
  logic          mvalid_q;
  logic [ecft_pkg::OutW-1:0] mdata_q;

  logic          is_mul;
  logic          mm_start, mm_done;
  logic [PB-1:0] mm_x, mm_prod;
  logic [YW-1:0] mm_y;
  logic [PB-1:0] half;
  logic [PB:0]   s1, s1r, s2, s2r, p_ext;
  logic          in_beat, out_load;

  logic signed [WW-1:0] trace_w, count_w;
  logic signed [TW-1:0] trace_sat;
  logic [NW-1:0]        count_sat;

  assign in_beat  = s_axis_tvalid && s_axis_tready;
  assign out_load = (state_q == ecft_pkg::ST_OUT) && (!mvalid_q || m_axis_tready);
  assign half     = (p_q - 1'b1) >> 1;
  assign p_ext    = {1'b0, p_q};

  // f = x^3 + ax + b, two modular adds; the first also gives 4a^3 + 27b^2
  always_comb begin
    s1  = {1'b0, t_q} + {1'b0, f_q};
    s1r = (s1 >= p_ext) ? s1 - p_ext : s1;
    s2  = s1r + {1'b0, b_q};
    s2r = (s2 >= p_ext) ? s2 - p_ext : s2;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ecft_pkg::ST_IDLE:
        if (in_beat) state_d = (p_q < PB'(3)) ? ecft_pkg::ST_OUT : ecft_pkg::ST_RED_A;
      ecft_pkg::ST_RED_A: if (mm_done) state_d = ecft_pkg::ST_RED_B;
      ecft_pkg::ST_RED_B: if (mm_done) state_d = ecft_pkg::ST_A2;
      ecft_pkg::ST_A2:    if (mm_done) state_d = ecft_pkg::ST_A3;
      ecft_pkg::ST_A3:    if (mm_done) state_d = ecft_pkg::ST_A4;
      ecft_pkg::ST_A4:    if (mm_done) state_d = ecft_pkg::ST_B2;
      ecft_pkg::ST_B2:    if (mm_done) state_d = ecft_pkg::ST_B27;
      ecft_pkg::ST_B27:   if (mm_done) state_d = ecft_pkg::ST_DISC;
      ecft_pkg::ST_DISC:
        state_d = (s1r == '0) ? ecft_pkg::ST_OUT : ecft_pkg::ST_X2;
      ecft_pkg::ST_X2:    if (mm_done) state_d = ecft_pkg::ST_X3;
      ecft_pkg::ST_X3:    if (mm_done) state_d = ecft_pkg::ST_AX;
      ecft_pkg::ST_AX:    if (mm_done) state_d = ecft_pkg::ST_FSUM;
      ecft_pkg::ST_FSUM:
        state_d = (s2r == '0) ? ecft_pkg::ST_NEXT : ecft_pkg::ST_PSQ;
      ecft_pkg::ST_PSQ:
        if (mm_done) begin
          if (half[bi_q])       state_d = ecft_pkg::ST_PMUL;
          else if (bi_q == '0)  state_d = ecft_pkg::ST_PCHK;
        end
      ecft_pkg::ST_PMUL:
        if (mm_done) state_d = (bi_q == '0) ? ecft_pkg::ST_PCHK : ecft_pkg::ST_PSQ;
      ecft_pkg::ST_PCHK:  state_d = ecft_pkg::ST_NEXT;
      ecft_pkg::ST_NEXT:
        state_d = (x_q == p_q - 1'b1) ? ecft_pkg::ST_OUT : ecft_pkg::ST_X2;
      ecft_pkg::ST_OUT:   if (out_load) state_d = ecft_pkg::ST_IDLE;
      default:            state_d = ecft_pkg::ST_IDLE;
    endcase
  end

  // outputs and multiplier operands
  always_comb begin
    is_mul = 1'b1;
    mm_x   = '0;
    mm_y   = '0;
    unique case (state_q)
      ecft_pkg::ST_RED_A: begin mm_x = PB'(1); mm_y = YW'(a_q); end
      ecft_pkg::ST_RED_B: begin mm_x = PB'(1); mm_y = YW'(b_q); end
      ecft_pkg::ST_A2:    begin mm_x = a_q;    mm_y = YW'(a_q); end
      ecft_pkg::ST_A3:    begin mm_x = t_q;    mm_y = YW'(a_q); end
      ecft_pkg::ST_A4:    begin mm_x = t_q;    mm_y = YW'(ecft_pkg::DiscK4); end
      ecft_pkg::ST_B2:    begin mm_x = b_q;    mm_y = YW'(b_q); end
      ecft_pkg::ST_B27:   begin mm_x = t_q;    mm_y = YW'(ecft_pkg::DiscK27); end
      ecft_pkg::ST_X2:    begin mm_x = x_q;    mm_y = YW'(x_q); end
      ecft_pkg::ST_X3:    begin mm_x = t_q;    mm_y = YW'(x_q); end
      ecft_pkg::ST_AX:    begin mm_x = a_q;    mm_y = YW'(x_q); end
      ecft_pkg::ST_PSQ:   begin mm_x = acc_q;  mm_y = YW'(acc_q); end
      ecft_pkg::ST_PMUL:  begin mm_x = acc_q;  mm_y = YW'(f_q); end
      default:            is_mul = 1'b0;
    endcase
    mm_start      = is_mul && !issued_q;
    s_axis_tready = (state_q == ecft_pkg::ST_IDLE);
    cfg_ready_o   = (state_q == ecft_pkg::ST_IDLE);
  end

  ecft_modmul #(
    .PB (PB),
    .YW (YW)
  ) u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mm_start),
    .x_i     (mm_x),
    .y_i     (mm_y),
    .p_i     (p_q),
    .done_o  (mm_done),
    .prod_o  (mm_prod)
  );

  // result formatting with saturation
  always_comb begin
    trace_w = -WW'(sum_q);
    count_w = $signed({{(WW-PB){1'b0}}, p_q}) + WW'(1) + WW'(sum_q);
    if (trace_w > 127)       trace_sat = TW'(127);
    else if (trace_w < -128) trace_sat = TW'(-128);
    else                     trace_sat = TW'(trace_w);
    if (count_w < 0)         count_sat = '0;
    else if (count_w > 2047) count_sat = '1;
    else                     count_sat = NW'(count_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ecft_pkg::ST_IDLE;
      p_q      <= PB'(587);
      issued_q <= 1'b0;
      mvalid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) p_q <= cfg_data_i;
      if (mm_done)       issued_q <= 1'b0;
      else if (mm_start) issued_q <= 1'b1;
      if (out_load)           mvalid_q <= 1'b1;
      else if (m_axis_tready) mvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      a_q    <= s_axis_tdata[PB-1:0];
      b_q    <= s_axis_tdata[2*PB-1:PB];
      good_q <= 1'b0;
    end
    if (mm_done) begin
      unique case (state_q)
        ecft_pkg::ST_RED_A: a_q   <= mm_prod;
        ecft_pkg::ST_RED_B: b_q   <= mm_prod;
        ecft_pkg::ST_A4,
        ecft_pkg::ST_AX:    f_q   <= mm_prod;
        ecft_pkg::ST_PSQ,
        ecft_pkg::ST_PMUL:  acc_q <= mm_prod;
        default:            t_q   <= mm_prod;
      endcase
    end
    case (state_q)
      ecft_pkg::ST_DISC: begin
        good_q <= (s1r != '0);
        x_q    <= '0;
        sum_q  <= '0;
      end
      ecft_pkg::ST_FSUM: begin
        f_q   <= s2r[PB-1:0];
        acc_q <= PB'(1);
        bi_q  <= BW'(PB - 1);
      end
      ecft_pkg::ST_PSQ:
        if (mm_done && !half[bi_q] && bi_q != '0) bi_q <= bi_q - 1'b1;
      ecft_pkg::ST_PMUL:
        if (mm_done && bi_q != '0) bi_q <= bi_q - 1'b1;
      ecft_pkg::ST_PCHK:
        sum_q <= (acc_q == PB'(1)) ? sum_q + SW'(1) : sum_q - SW'(1);
      ecft_pkg::ST_NEXT:
        x_q <= x_q + 1'b1;
      default: ;
    endcase
    if (out_load) begin
      mdata_q <= good_q ? {{(ecft_pkg::OutW-1-TW-NW){1'b0}}, count_sat, trace_sat, 1'b1}
                        : '0;
    end
  end

  assign m_axis_tvalid = mvalid_q;
  assign m_axis_tdata  = mdata_q;

  // the multiplier only finishes a product that was requested
  a_done_issued: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mm_done |-> issued_q)
    else $error("multiplier finished without a request");

  a_x_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ecft_pkg::ST_X2 || state_q == ecft_pkg::ST_NEXT) |-> (x_q < p_q))
    else $error("x walked past the modulus");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[TW+NW:1] == '0))
    else $error("bad reduction with nonzero trace or count");

endmodule

/* tb/sv/elliptic_curve_frobenius_trace_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// elliptic_curve_frobenius_trace_tb
// Self-checking bench for the Frobenius trace and point count block.
// ----------------------------------------------------------------------------
// Coefficient pairs are streamed in under several moduli: the reset value, the
// widest register value, the degenerate moduli below three and a spread of
// small primes and composites. Each result beat is checked field by field
// against a local Legendre-sum calculation. Random gaps on both sides.
// ----------------------------------------------------------------------------
module elliptic_curve_frobenius_trace_tb;

  localparam int unsigned PBits   = 10;
  localparam int unsigned InW     = ((2 * PBits + 7) / 8) * 8;
  localparam int unsigned IdleMax = 2000000;

  typedef struct packed {
    logic                               good;
    logic signed [ecft_pkg::TraceW-1:0] trace;
    logic [ecft_pkg::CountW-1:0]        count;
  } curve_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [PBits-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [InW-1:0]   s_axis_tdata = '0;   // coeff_a, coeff_b, zero fill
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // good_reduction, frobenius_trace, point_count
  logic [ecft_pkg::OutW-1:0] m_axis_tdata;

  curve_res_t  trace_q[$];
  int unsigned modulus = 587;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;

  elliptic_curve_frobenius_trace #(.PRIME_BITS(PBits)) dut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // legendre character sum over every x, as the block walks it
  function automatic curve_res_t count_points(int unsigned p, int unsigned ca,
                                              int unsigned cb);
    curve_res_t r;
    longint unsigned a, b, disc, f, acc, base, e;
    int sum, trace, cnt;
    r = '0;
    sum = 0;
    if (p < 3) return r;
    a = ca % p;
    b = cb % p;
    disc = (ecft_pkg::DiscK4 * ((a * a % p) * a % p) +
            ecft_pkg::DiscK27 * (b * b % p)) % p;
    if (disc == 0) return r;
    for (longint unsigned x = 0; x < p; x++) begin
      f = ((x * x % p) * x % p + a * x % p + b) % p;
      if (f != 0) begin
        acc = 1;
        base = f;
        e = (p - 1) / 2;
        while (e != 0) begin
          if (e[0]) acc = acc * base % p;
          base = base * base % p;
          e = e >> 1;
        end
        sum += (acc == 1) ? 1 : -1;
      end
    end
    trace = -sum;
    cnt = int'(p) + 1 - trace;
    if (cnt < 0) cnt = 0;
    if (cnt > 2047) cnt = 2047;
    r.good = 1'b1;
    r.trace = (trace > 127) ? 8'sd127 : (trace < -128) ? -8'sd128 :
              trace[ecft_pkg::TraceW-1:0];
    r.count = cnt[ecft_pkg::CountW-1:0];
    return r;
  endfunction

  task automatic report(string what, curve_res_t got, curve_res_t want);
    $display("mismatch %s: got good=%0d trace=%0d count=%0d, want good=%0d trace=%0d count=%0d",
             what, got.good, got.trace, got.count, want.good, want.trace, want.count);
    errors++;
  endtask

  task automatic pause(int unsigned n);
    repeat (n) @(posedge clk_i);
  endtask

  // mostly back to back, sometimes short, rarely long
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_curve(int unsigned ca, int unsigned cb);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(InW - 2 * PBits){1'b0}}, cb[PBits-1:0], ca[PBits-1:0]};
    do @(posedge clk_i); while (!s_axis_tready);
    trace_q = {trace_q, count_points(modulus, ca, cb)};
  endtask

  task automatic drain_and_gap(int unsigned n);
    if (n > 0) begin
      s_axis_tvalid <= 1'b0;
      pause(n);
    end
  endtask

  task automatic set_modulus(int unsigned p);
    s_axis_tvalid <= 1'b0;
    wait (trace_q.size() == 0);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= p[PBits-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    modulus = p;
  endtask

  task automatic test_reset_modulus();
    send_curve(0, 0);          // singular
    drain_and_gap(pick_gap());
    send_curve(1023, 1023);    // both above the prime
    drain_and_gap(pick_gap());
  endtask

  task automatic test_widest_modulus();
    set_modulus(1023);         // composite, all register bits set
    send_curve(1, 1);
    drain_and_gap(pick_gap());
  endtask

  task automatic test_degenerate_moduli();
    set_modulus(0);
    send_curve(5, 7);
    drain_and_gap(1);
    set_modulus(1);
    send_curve(1023, 0);
    drain_and_gap(1);
    set_modulus(2);
    send_curve(0, 1023);
    drain_and_gap(1);
  endtask

  task automatic test_smallest_prime();
    set_modulus(3);
    for (int unsigned a = 0; a < 3; a++)
      for (int unsigned b = 0; b < 3; b++) begin
        send_curve(a, b);
        drain_and_gap(pick_gap());
      end
  endtask

  task automatic test_random_curves();
    int unsigned moduli[] = '{5, 7, 11, 13, 17, 19, 23, 29, 31, 9, 15, 2, 41, 3};
    int unsigned p;
    for (int i = 0; i < 100; i++) begin
      if (i % 10 == 0) begin
        p = moduli[$urandom_range(0, moduli.size() - 1)];
        set_modulus(p);
      end
      // coefficients below the modulus mostly, any 10-bit value now and then
      if ($urandom_range(0, 3) == 0 || p == 0)
        send_curve($urandom_range(0, 1023), $urandom_range(0, 1023));
      else
        send_curve($urandom_range(0, p - 1), $urandom_range(0, p - 1));
      drain_and_gap(pick_gap());
    end
    s_axis_tvalid <= 1'b0;
  endtask

  // result side: stalls in runs, with stretches of steady ready
  always @(posedge clk_i) begin
    if ($urandom_range(0, 7) != 0) m_axis_tready <= ($urandom_range(0, 3) != 0);
  end

  always @(posedge clk_i) begin
    curve_res_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{good: m_axis_tdata[0], trace: m_axis_tdata[ecft_pkg::TraceW:1],
              count: m_axis_tdata[ecft_pkg::TraceW+ecft_pkg::CountW:ecft_pkg::TraceW+1]};
      if (trace_q.size() == 0) begin
        report("unexpected beat", got, '0);
      end else begin
        want = trace_q.pop_front();
        if (got.good !== want.good) report("good_reduction", got, want);
        if (got.trace !== want.trace) report("frobenius_trace", got, want);
        if (got.count !== want.count) report("point_count", got, want);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleMax) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    pause(8);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_modulus();
    test_widest_modulus();
    test_degenerate_moduli();
    test_smallest_prime();
    test_random_curves();
    wait (trace_q.size() == 0);
    pause(20);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
